// ===== rtl/dpmm_pkg.sv =====
// Shared widths, constants and sequencer state type for the dyadic pattern multiply.
`default_nettype none

package dpmm_pkg;

    localparam int IDX_W   = 5;    // element index width
    localparam int ELEM_W  = 16;   // operand element width
    localparam int PROD_W  = 32;   // width of one product
    localparam int VAL_W   = 37;   // result element width
    localparam int LG_W    = 3;    // length_log2 register width
    localparam int CNT_W   = 6;    // counter able to hold the largest length
    localparam int LG_HARD_MAX = 5;

    localparam logic [LG_W-1:0] LG_RESET = 3'd2;
    localparam logic [LG_W-1:0] LG_MIN   = 3'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/dpmm_in_if.sv =====
// Input channel: one element pair per transaction, with its index and the last mark.
`default_nettype none

interface dpmm_in_if;
    import dpmm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     load_done;

    modport source (output valid, output elem_index, output a_elem, output b_elem,
                    output load_done, input ready);
    modport sink   (input valid, input elem_index, input a_elem, input b_elem,
                    input load_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpmm_out_if.sv =====
// Output channel: one result element per transaction.
`default_nettype none

interface dpmm_out_if;
    import dpmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;

    modport source (output valid, output out_index, output out_value, output out_last,
                    input ready);
    modport sink   (input valid, input out_index, input out_value, input out_last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/dyadic_pattern_matrix_multiply.sv =====
// Top level: element stores and a shared multiply-accumulate computing the XOR convolution.
`default_nettype none

// The block takes one element pair per cycle while idle into its a and b stores, each transaction
// writing entry elem_index modulo L, where L = 2**length_log2 (clamped to 1..5 and to
// MAX_LEN). The transaction marked load_done also writes, then starts the run: the block
// drops ready and emits L results c[m] = sum_i a[i]*b[i^m] in index order, out_last on
// m = L-1. The run is serial: each result also waits for its output handshake, and a single
// multiply-accumulate unit, fed by one read port on each store, forms every product in turn.
// Stores are not cleared; entries persist across runs. The user must write length_log2 only
// while the block is idle; the block itself does not enforce this.
module dyadic_pattern_matrix_multiply #(
    parameter int MAX_LEN = 32
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire [dpmm_pkg::LG_W-1:0]   cfg_data,
    dpmm_in_if.sink                    in_ch,
    dpmm_out_if.source                 out_ch
);
    import dpmm_pkg::*;

    localparam int AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LG_FLOOR  = $clog2(MAX_LEN + 1) - 1;
    localparam int LG_MAX_I  = (LG_FLOOR < LG_HARD_MAX) ? LG_FLOOR : LG_HARD_MAX;
    localparam logic [LG_W-1:0] LG_MAX = LG_W'(LG_MAX_I);

    logic [LG_W-1:0]          length_log2_reg;
    logic [LG_W-1:0]          eff_lg;
    logic [CNT_W-1:0]         len_cnt;
    logic [IDX_W-1:0]         idx_mask;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [IDX_W-1:0]         m_reg, m_next;
    logic                     rd_vld_reg, mul_vld_reg;
    logic                     issue, acc_clr, in_accept, last_elem;

    logic signed [ELEM_W-1:0] a_mem [MAX_LEN];
    logic signed [ELEM_W-1:0] b_mem [MAX_LEN];
    logic signed [ELEM_W-1:0] a_q_reg, b_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  acc_reg;
    logic [AW-1:0]            wr_addr, a_addr, b_addr;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_log2_reg <= LG_RESET;
        end
        else if (cfg_we)
        begin
            length_log2_reg <= cfg_data;
        end
    end

    always_comb
    begin
        priority if (length_log2_reg < LG_MIN)
        begin
            eff_lg = LG_MIN;
        end
        else if (length_log2_reg > LG_MAX)
        begin
            eff_lg = LG_MAX;
        end
        else
        begin
            eff_lg = length_log2_reg;
        end
    end

    assign len_cnt   = CNT_W'(1) << eff_lg;
    assign idx_mask  = IDX_W'(len_cnt - CNT_W'(1));
    assign last_elem = (m_reg == idx_mask);

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign issue   = (state_reg == ST_RUN) && (i_reg != len_cnt);
    assign wr_addr = AW'(in_ch.elem_index & idx_mask);
    assign a_addr  = AW'(i_reg[IDX_W-1:0]);
    assign b_addr  = AW'(i_reg[IDX_W-1:0] ^ m_reg);

    // Element stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_mem[wr_addr] <= in_ch.a_elem;
            b_mem[wr_addr] <= in_ch.b_elem;
        end
        a_q_reg <= a_mem[a_addr];
        b_q_reg <= b_mem[b_addr];
    end

    // Shared multiply-accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= a_q_reg * b_q_reg;
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + VAL_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            m_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            m_reg       <= m_next;
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        acc_clr    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.load_done)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    m_next     = '0;
                    acc_clr    = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        m_next     = m_reg + IDX_W'(1);
                        i_next     = '0;
                        acc_clr    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the finished sum until the transaction completes
    assign out_ch.valid     = (state_reg == ST_EMIT);
    assign out_ch.out_index = m_reg;
    assign out_ch.out_value = acc_reg;
    assign out_ch.out_last  = last_elem;

endmodule

`default_nettype wire

// ===== rtl/dpmm_checker.sv =====
// Port-level checker for the dyadic pattern multiply, bound to the top level.
`default_nettype none

module dpmm_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           in_valid,
    input wire                           in_ready,
    input wire                           in_load_done,
    input wire                           out_valid,
    input wire                           out_ready,
    input wire [dpmm_pkg::IDX_W-1:0]     out_index,
    input wire [dpmm_pkg::VAL_W-1:0]     out_value,
    input wire                           out_last
);
    import dpmm_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) &&
        $stable(out_value) && $stable(out_last))
        else $error("stalled result changed");

    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    // The last element starts a run
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_load_done |=> !in_ready)
        else $error("ready stayed high after last element");

    // A plain load emits nothing and stays ready
    a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_load_done |=> in_ready && !out_valid)
        else $error("plain load left idle");

    // The final result returns the block to loading
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready)
        else $error("not ready after final result");

endmodule

bind dyadic_pattern_matrix_multiply dpmm_checker u_dpmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_load_done (in_ch.load_done),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_index    (out_ch.out_index),
    .out_value    (out_ch.out_value),
    .out_last     (out_ch.out_last)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for dyadic_pattern_matrix_multiply: directed table, random runs, XOR predictor.
`timescale 1ns / 1ps

module tb_top;
    import dpmm_pkg::*;

    localparam int MAX_LEN     = 32;
    localparam int NO_CFG      = -1;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int DRAIN_WAIT  = 64;
    localparam int PHASE_ITEMS = 38;

    typedef struct {
        logic [IDX_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } conv_result_t;

    typedef struct {
        int                       set_lg;
        logic [IDX_W-1:0]         pos;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic                     done;
        bit                       typed;
        longint                   value;
    } load_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [LG_W-1:0] cfg_data;

    dpmm_in_if  in_ch();
    dpmm_out_if out_ch();

    dyadic_pattern_matrix_multiply #(.MAX_LEN(MAX_LEN)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Predictor state: shadow copy of the length register and both element stores
    logic [LG_W-1:0]          len_log2_q;
    logic signed [ELEM_W-1:0] a_copy [MAX_LEN];
    logic signed [ELEM_W-1:0] b_copy [MAX_LEN];
    bit [MAX_LEN-1:0]         filled;

    conv_result_t pending_sums [$];
    load_row_t    directed_rows [$];
    int           phase_lg [$];

    int mismatches = 0;
    int cycle_count = 0;
    int in_quiet = 0;
    int out_stall = 0;
    int out_quiet = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, pending_sums.size());
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int active_len();
        int lg;
        lg = int'(len_log2_q);
        if (lg < int'(LG_MIN))
            lg = int'(LG_MIN);
        if (lg > LG_HARD_MAX)
            lg = LG_HARD_MAX;
        while (lg > 1 && (1 << lg) > MAX_LEN)
            lg--;
        return 1 << lg;
    endfunction

    function automatic bit stores_cover(input bit [MAX_LEN-1:0] mask_in, input int len);
        bit [MAX_LEN-1:0] need;
        need = MAX_LEN'((64'd1 << len) - 64'd1);
        return (mask_in & need) == need;
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_elem();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            3: return -16'sd1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic void add_row(input int set_lg, input int pos, input int a, input int b,
                                    input bit done, input bit typed, input longint value);
        load_row_t row;
        row.set_lg = set_lg;
        row.pos    = IDX_W'(pos);
        row.a      = ELEM_W'(a);
        row.b      = ELEM_W'(b);
        row.done   = done;
        row.typed  = typed;
        row.value  = value;
        directed_rows.push_back(row);
    endfunction

    // Store an accepted element; on the last mark, queue the full convolution
    task automatic take_elem(input logic [IDX_W-1:0] pos, input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b, input logic done,
                             input bit typed, input longint typed_value);
        int len;
        int slot;
        longint acc;
        conv_result_t res;
        len = active_len();
        slot = int'(pos) & (len - 1);
        a_copy[slot] = a;
        b_copy[slot] = b;
        filled[slot] = 1'b1;
        if (done)
        begin
            for (int m = 0; m < len; m++)
            begin
                acc = 0;
                for (int i = 0; i < len; i++)
                    acc += longint'(a_copy[i]) * longint'(b_copy[i ^ m]);
                res.pos   = IDX_W'(m);
                res.value = typed ? VAL_W'(typed_value) : VAL_W'(acc);
                res.last  = (m == len - 1);
                pending_sums.push_back(res);
            end
        end
    endtask

    task automatic send_elem(input logic [IDX_W-1:0] pos, input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b, input logic done,
                             input bit typed, input longint typed_value);
        int gap;
        if (in_quiet > 0)
        begin
            gap = 0;
            in_quiet--;
        end
        else
        begin
            gap = draw_gap();
            if ($urandom_range(0, 99) < 4)
                in_quiet = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.elem_index <= pos;
        in_ch.a_elem     <= a;
        in_ch.b_elem     <= b;
        in_ch.load_done  <= done;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        take_elem(pos, a, b, done, typed, typed_value);
    endtask

    // Drain every pending result, let the block settle, then write the length register
    task automatic write_length(input logic [LG_W-1:0] lg);
        in_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= lg;
        @(posedge clk);
        cfg_we <= 1'b0;
        len_log2_q = lg;
    endtask

    task automatic run_phase(input logic [LG_W-1:0] lg);
        int len;
        int sent;
        int kind;
        int n;
        int j;
        int t;
        int pos;
        int order [$];
        bit extreme;
        logic signed [ELEM_W-1:0] ea;
        logic signed [ELEM_W-1:0] eb;
        logic done;
        write_length(lg);
        len = active_len();
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // Complete load in shuffled order, upper index bits random so they wrap
                order.delete();
                for (int k = 0; k < len; k++)
                    order.push_back(k);
                for (int k = len - 1; k > 0; k--)
                begin
                    j = $urandom_range(0, k);
                    t = order[k];
                    order[k] = order[j];
                    order[j] = t;
                end
                extreme = (kind < 10);
                ea = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                eb = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                for (int k = 0; k < len; k++)
                begin
                    pos = order[k] + len * $urandom_range(0, MAX_LEN / len - 1);
                    send_elem(IDX_W'(pos), extreme ? ea : pick_elem(), extreme ? eb : pick_elem(),
                              k == len - 1, 1'b0, 0);
                end
                sent += len;
            end
            else
            begin
                // Partial update reusing old entries, or noise that never starts a run
                n = (kind < 85) ? $urandom_range(1, len) : $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    pos = $urandom_range(0, MAX_LEN - 1);
                    done = 1'b0;
                    if (kind < 85 && k == n - 1)
                        done = stores_cover(filled | (MAX_LEN'(1) << (pos & (len - 1))), len);
                    send_elem(IDX_W'(pos), pick_elem(), pick_elem(), done, 1'b0, 0);
                end
                sent += n;
            end
        end
    endtask

    // Result side: random backpressure, compare each transaction with the oldest expectation
    always @(posedge clk)
    begin
        conv_result_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $display("%0t: unexpected result index %0d value %0d", $time,
                             out_ch.out_index, out_ch.out_value);
                    mismatches++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (out_ch.out_index !== want.pos)
                    begin
                        $display("%0t: out_index expected %0d actual %0d", $time,
                                 want.pos, out_ch.out_index);
                        mismatches++;
                    end
                    if (out_ch.out_value !== want.value)
                    begin
                        $display("%0t: out_value[%0d] expected %0d actual %0d", $time,
                                 want.pos, want.value, out_ch.out_value);
                        mismatches++;
                    end
                    if (out_ch.out_last !== want.last)
                    begin
                        $display("%0t: out_last[%0d] expected %0b actual %0b", $time,
                                 want.pos, want.last, out_ch.out_last);
                        mismatches++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_quiet > 0)
                    out_quiet <= out_quiet - 1;
                else if ($urandom_range(0, 99) < 3)
                    out_quiet <= $urandom_range(30, 120);
                else
                    out_stall <= draw_gap();
            end
        end
    end

    initial
    begin
        load_row_t row;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.elem_index <= '0;
        in_ch.a_elem     <= '0;
        in_ch.b_elem     <= '0;
        in_ch.load_done  <= 1'b0;
        len_log2_q = LG_RESET;
        filled = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            a_copy[i] = '0;
            b_copy[i] = '0;
        end

        // Reset length of four: both operands at the negative extreme
        add_row(NO_CFG, 0, -32768, -32768, 1'b0, 1'b0, 0);
        add_row(NO_CFG, 1, -32768, -32768, 1'b0, 1'b0, 0);
        add_row(NO_CFG, 2, -32768, -32768, 1'b0, 1'b0, 0);
        add_row(NO_CFG, 3, -32768, -32768, 1'b1, 1'b1, 64'sd4294967296);
        // Single wrapped write that also starts a run over persisting entries
        add_row(NO_CFG, 5, 32767, -32768, 1'b1, 1'b0, 0);
        // Length register below range saturates to two
        add_row(0, 31, 32767, 32767, 1'b0, 1'b0, 0);
        add_row(NO_CFG, 30, 32767, 32767, 1'b1, 1'b1, 64'sd2147352578);
        // Length eight, indices 8 to 15 wrap onto 0 to 7
        add_row(3, 8, -32768, 32767, 1'b0, 1'b0, 0);
        for (int k = 9; k < 15; k++)
            add_row(NO_CFG, k, -32768, 32767, 1'b0, 1'b0, 0);
        add_row(NO_CFG, 15, -32768, 32767, 1'b1, 1'b1, -64'sd8589672448);
        // Length two again, reusing stored entries
        add_row(1, 16, 0, 0, 1'b1, 1'b0, 0);
        add_row(NO_CFG, 1, -1, -1, 1'b0, 1'b0, 0);
        add_row(NO_CFG, 0, 1, -1, 1'b1, 1'b0, 0);

        phase_lg = '{5, 2, 7, 1, 3, 6, 4, 0, 5};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.set_lg != NO_CFG)
                write_length(LG_W'(row.set_lg));
            send_elem(row.pos, row.a, row.b, row.done, row.typed, row.value);
        end

        foreach (phase_lg[p])
            run_phase(LG_W'(phase_lg[p]));

        in_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dpmm_pkg.sv
rtl/dpmm_in_if.sv
rtl/dpmm_out_if.sv
rtl/dyadic_pattern_matrix_multiply.sv
rtl/dpmm_checker.sv
tb/tb_top.sv
